>>> hw/rtl/mct_pkg.sv
// Shared types and constants for the multiset count table.
// No dependencies; every other file of the block imports this package.
package mct_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 16;
  localparam int AMT_W = 16;
  localparam int ST_W  = 3;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Result codes
  typedef enum logic [ST_W-1:0] {
    ST_NEW       = 3'd0,
    ST_INC       = 3'd1,
    ST_DEC       = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // Input action codes
  typedef enum logic {
    ACT_ADD    = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             vld;
    action_t          action;
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
    logic             hit;
    logic [CNT_W-1:0] hit_count;
    logic             free;
  } tok_t;

  // Update command broadcast to the cells that marked themselves
  typedef struct packed {
    logic             hit_wr;
    logic             hit_free;
    logic             insert;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

>>> hw/rtl/mct_if.sv
// Valid/ready channel interfaces for the multiset count table.
// Depends on mct_pkg for field widths.
interface mct_in_if import mct_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [KEY_W-1:0] key_value;
  logic        [AMT_W-1:0] amount;

  modport source (output valid, action, key_value, amount, input ready);
  modport sink   (input valid, action, key_value, amount, output ready);
endinterface

interface mct_out_if import mct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] count_after;
  logic             saturated;

  modport source (output valid, status, count_after, saturated, input ready);
  modport sink   (input valid, status, count_after, saturated, output ready);
endinterface

>>> hw/rtl/mct_cell.sv
// One table entry: valid bit, key and count, plus the stage of the search chain.
// Depends on mct_pkg for the token and command types.
module mct_cell import mct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic stall,
  input  tok_t tok_in,
  output tok_t tok_out,
  input  cmd_t cmd
);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] count_r;
  logic             hit_mark_r;
  logic             free_mark_r;
  tok_t             tok_r;
  tok_t             tok_nxt;
  logic             hit_here;
  logic             free_here;

  // Claim the first match and the first free entry seen by this token
  always_comb begin
    hit_here  = tok_in.vld && !tok_in.hit && valid_r && (key_r == tok_in.key);
    free_here = tok_in.vld && !tok_in.free && !valid_r;
    tok_nxt   = tok_in;
    if (hit_here) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.hit_count = count_r;
    end
    if (free_here) begin
      tok_nxt.free = 1'b1;
    end
  end

  // Advance the token and remember this cell's role for the pending item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (!stall) begin
      tok_r <= tok_nxt;
    end
    if (!stall && tok_in.vld) begin
      hit_mark_r  <= hit_here;
      free_mark_r <= free_here;
    end
  end

  // Apply the broadcast update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (cmd.hit_free && hit_mark_r) begin
        valid_r <= 1'b0;
      end
      if (cmd.insert && free_mark_r) begin
        valid_r <= 1'b1;
      end
    end
    if (cmd.hit_wr && hit_mark_r) begin
      count_r <= cmd.count;
    end
    if (cmd.insert && free_mark_r) begin
      key_r   <= cmd.key;
      count_r <= cmd.count;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> hw/rtl/mct_ctrl.sv
// End of the search chain: decides the update, issues it and registers the result.
// Depends on mct_pkg for the token, command and status types.
module mct_ctrl import mct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tok_t             tok_last,
  output logic             stall,
  output logic             done,
  output cmd_t             cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  out_status,
  output logic [CNT_W-1:0] out_count,
  output logic             out_sat
);

  logic             out_vld_r;
  status_t          status_r;
  status_t          status_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             sat_r;
  logic             sat_nxt;
  logic [CNT_W:0]   sum;
  cmd_t             cmd_raw;

  // Hold the chain while a finished result is still waiting
  assign stall = tok_last.vld && out_vld_r && !out_ready;
  assign done  = tok_last.vld && !stall;

  // Decide the update from the search outcome
  always_comb begin
    sum         = {1'b0, tok_last.hit_count} + {1'b0, tok_last.amount};
    cmd_raw     = '0;
    cmd_raw.key = tok_last.key;
    status_nxt  = ST_NOT_FOUND;
    count_nxt   = '0;
    sat_nxt     = 1'b0;
    if (tok_last.action == ACT_ADD) begin
      if (tok_last.hit) begin
        sat_nxt        = sum[CNT_W];
        count_nxt      = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        cmd_raw.hit_wr = 1'b1;
        status_nxt     = ST_INC;
      end else if (tok_last.free) begin
        count_nxt      = tok_last.amount;
        cmd_raw.insert = 1'b1;
        status_nxt     = ST_NEW;
      end else begin
        status_nxt = ST_FULL;
      end
    end else begin
      if (tok_last.hit) begin
        if (tok_last.hit_count > CNT_ONE) begin
          count_nxt      = tok_last.hit_count - CNT_ONE;
          cmd_raw.hit_wr = 1'b1;
          status_nxt     = ST_DEC;
        end else begin
          cmd_raw.hit_free = 1'b1;
          status_nxt       = ST_REMOVED;
        end
      end
    end
    cmd_raw.count = count_nxt;
  end

  // Gate the broadcast with the finishing cycle
  always_comb begin
    cmd          = cmd_raw;
    cmd.hit_wr   = cmd_raw.hit_wr & done;
    cmd.hit_free = cmd_raw.hit_free & done;
    cmd.insert   = cmd_raw.insert & done;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (done) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (done) begin
      status_r <= status_nxt;
      count_r  <= count_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_status = status_r;
  assign out_count  = count_r;
  assign out_sat    = sat_r;

endmodule

>>> hw/rtl/multiset_count_table.sv
// Multiset count table: an input channel of add/remove items and a result channel.
// Every item gives exactly one result: status, count after the operation and a
// saturation flag. Add raises a matching key's count (clipped at 65535) or
// stores the key in the lowest free entry; remove lowers or frees the entry.
// The table is a row of TABLE_DEPTH cells. An accepted item becomes a token
// that walks the row one cell per cycle, each cell claiming a match or a free
// slot; at the end of the row the update is broadcast to the claiming cell and
// the result is registered.
// One item is in the row at a time, so a new item is accepted only after the
// last one has left the row. The next item may be accepted while a result
// still waits on the output.
// If the receiver stalls, the token holds at the end of the row until the
// output register is free, and in_chan.ready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the table and drops any item in
// flight; the block is ready in the cycle after reset is released.
// Depends on mct_pkg, mct_if, mct_cell and mct_ctrl.
module multiset_count_table import mct_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mct_in_if.sink     in_chan,
  mct_out_if.source  out_chan
);

  tok_t                 tok [TABLE_DEPTH+1];
  tok_t                 tok0_r;
  logic [TABLE_DEPTH:0] tok_vld;
  logic                 busy_r;
  logic                 in_fire;
  logic                 stall;
  logic                 done;
  cmd_t                 cmd;

  assign in_chan.ready = !busy_r;
  assign in_fire       = in_chan.valid && !busy_r;

  // Track the single item in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // Load a fresh token at the head of the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.vld <= 1'b0;
    end else begin
      tok0_r.vld <= in_fire;
    end
    if (in_fire) begin
      tok0_r.action    <= action_t'(in_chan.action);
      tok0_r.key       <= $unsigned(in_chan.key_value);
      tok0_r.amount    <= in_chan.amount;
      tok0_r.hit       <= 1'b0;
      tok0_r.hit_count <= '0;
      tok0_r.free      <= 1'b0;
    end
  end

  assign tok[0] = tok0_r;

  // Row of table cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mct_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stall   (stall),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .cmd     (cmd)
    );
  end

  mct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_last   (tok[TABLE_DEPTH]),
    .stall      (stall),
    .done       (done),
    .cmd        (cmd),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_status (out_chan.status),
    .out_count  (out_chan.count_after),
    .out_sat    (out_chan.saturated)
  );

  always_comb begin
    for (int k = 0; k <= TABLE_DEPTH; k++) begin
      tok_vld[k] = tok[k].vld;
    end
  end

  // At most one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld) <= 1)
    else $error("more than one token in the cell row");

  // A token in the row means the block is busy
  a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_vld != '0) |-> busy_r)
    else $error("token in flight while the block is not busy");

  // An accepted item enters the head of the row
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> tok_vld[0])
    else $error("accepted item did not enter the row");

  // A removed or absent key reports zero and no saturation
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_REMOVED ||
                        out_chan.status == ST_NOT_FOUND ||
                        out_chan.status == ST_FULL))
    |-> (out_chan.count_after == '0 && !out_chan.saturated))
    else $error("non-zero result for an absent key");

endmodule
